// ----- sv/hbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants of the hysteresis beat detector
// Field widths, ring geometry, register indexes and bus layouts.
// ----------------------------------------------------------------------------
package hbd_pkg;

	localparam int INTERVAL_SLOTS = 5;
	localparam int RATE_NUMERATOR = 60000;

	localparam int SAMPLE_W = 12;
	localparam int TIME_W   = 32;
	localparam int REFR_W   = 16;
	localparam int MINV_W   = 3;
	localparam int RATE_W   = 16;

	localparam int SUM_W  = TIME_W + $clog2(INTERVAL_SLOTS);
	localparam int CNT_W  = $clog2(INTERVAL_SLOTS + 1);
	localparam int PTR_W  = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
	localparam int ITER_W = $clog2(SUM_W + 1);
	localparam int CMP_W  = (CNT_W > MINV_W) ? CNT_W : MINV_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
	localparam int OUT_BITS   = 1 + RATE_W + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MINV  = 2'd3;

	localparam logic [REFR_W-1:0] REFR_RESET = 16'd300;
	localparam logic [MINV_W-1:0] MINV_RESET = 3'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] upper;
		logic [SAMPLE_W-1:0] lower;
		logic [REFR_W-1:0]   refr;
		logic [MINV_W-1:0]   min_valid;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic update;
	} det_ctrl_t;

	typedef struct packed {
		logic             beat;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} det_stat_t;

endpackage

// ----- sv/hbd_detect.sv -----
// ----------------------------------------------------------------------------
// hbd_detect: beat decision and interval ring
// Hysteresis with refractory test, ring of intervals, running sum and count.
// ----------------------------------------------------------------------------
module hbd_detect import hbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  det_ctrl_t           ctrl,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]   now_ms,
	output det_stat_t           stat
);

	logic [SAMPLE_W-1:0] sample_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [TIME_W-1:0]   elapsed_s1;
	logic [TIME_W-1:0]   old_s2;
	logic                store_s2;

	logic                in_beat_q;
	logic                have_last_q;
	logic                beat_q;
	logic [TIME_W-1:0]   last_beat_q;
	logic [TIME_W-1:0]   ring_q [INTERVAL_SLOTS];
	logic [PTR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;

	logic start;

	assign start = (sample_s1 > cfg.upper) && !in_beat_q &&
		(!have_last_q || (elapsed_s1 > TIME_W'(cfg.refr)));

	// take the item and the time since the last beat
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			sample_s1  <= sample;
			now_s1     <= now_ms;
			elapsed_s1 <= now_ms - last_beat_q;
		end
		if (ctrl.decide) begin
			old_s2 <= ring_q[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_beat_q   <= 1'b0;
			have_last_q <= 1'b0;
			beat_q      <= 1'b0;
			store_s2    <= 1'b0;
			last_beat_q <= '0;
			ptr_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			for (int i = 0; i < INTERVAL_SLOTS; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (ctrl.decide) begin
				beat_q   <= start;
				store_s2 <= start && have_last_q;
				if (start) begin
					in_beat_q   <= 1'b1;
					have_last_q <= 1'b1;
					last_beat_q <= now_s1;
					if (have_last_q) begin
						ring_q[ptr_q] <= elapsed_s1;
						ptr_q <= (ptr_q == PTR_W'(INTERVAL_SLOTS - 1)) ? '0 : ptr_q + 1'b1;
						if (count_q != CNT_W'(INTERVAL_SLOTS)) begin
							count_q <= count_q + 1'b1;
						end
					end
				end else if ((sample_s1 < cfg.lower) && in_beat_q) begin
					in_beat_q <= 1'b0;
				end
			end
			// replace the overwritten slot in the running sum
			if (ctrl.update && store_s2) begin
				sum_q <= sum_q + SUM_W'(elapsed_s1) - SUM_W'(old_s2);
			end
		end
	end

	assign stat.beat  = beat_q;
	assign stat.sum   = sum_q;
	assign stat.count = count_q;

endmodule

// ----- sv/hbd_div.sv -----
// ----------------------------------------------------------------------------
// hbd_div: bit-serial restoring divider
// One quotient bit per cycle, dividend shifted in from the top bit.
// ----------------------------------------------------------------------------
module hbd_div import hbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [SUM_W-1:0]  divisor,
	input  logic [ITER_W-1:0] iters,
	output logic              busy,
	output logic [SUM_W-1:0]  quotient
);

	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [SUM_W-1:0]  dsr_q;
	logic [SUM_W-1:0]  quo_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;

	logic [SUM_W:0] trial;
	logic [SUM_W:0] diff;
	logic           ge;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- sv/hysteresis_beat_detector_unit.sv -----
// ----------------------------------------------------------------------------
// hysteresis_beat_detector_unit: pulse beat detector with average rate
// After acceptance an item passes the decide and sum-update states, then the bit-serial
// divider finds the mean interval and then the rate, and the report is loaded for m_tvalid.
// A new item is accepted only in idle, once the previous report has been loaded for output.
// Reset clears the ring, sum, count and beat state, and loads register defaults.
// ----------------------------------------------------------------------------
module hysteresis_beat_detector_unit import hbd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // sample[11:0], now_ms[43:12], zero fill
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // beat_start[0], heart_rate[16:1], rate_valid[17]
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_S1   = 3'd3;
	localparam logic [2:0] ST_W1   = 3'd4;
	localparam logic [2:0] ST_S2   = 3'd5;
	localparam logic [2:0] ST_W2   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	cfg_t       cfg_q;
	det_ctrl_t  ctrl;
	det_stat_t  stat;

	logic              div_start;
	logic              div_busy;
	logic [SUM_W-1:0]  div_dividend;
	logic [SUM_W-1:0]  div_divisor;
	logic [ITER_W-1:0] div_iters;
	logic [SUM_W-1:0]  quotient;

	logic              accept;
	logic              out_load;
	logic              rate_ok;
	logic              m_valid_q;
	logic              beat_q;
	logic              valid_q;
	logic [RATE_W-1:0] rate_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper     <= '0;
			cfg_q.lower     <= '0;
			cfg_q.refr      <= REFR_RESET;
			cfg_q.min_valid <= MINV_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UPPER: cfg_q.upper     <= cfg_data[SAMPLE_W-1:0];
				REG_LOWER: cfg_q.lower     <= cfg_data[SAMPLE_W-1:0];
				REG_REFR:  cfg_q.refr      <= cfg_data[REFR_W-1:0];
				REG_MINV:  cfg_q.min_valid <= cfg_data[MINV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DEC;
				ST_DEC:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_S1;
				ST_S1:   state_q <= ST_W1;
				ST_W1:   if (!div_busy) state_q <= ST_S2;
				ST_S2:   state_q <= ST_W2;
				ST_W2:   if (!div_busy) state_q <= ST_OUT;
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ctrl.capture = accept;
	assign ctrl.decide  = (state_q == ST_DEC);
	assign ctrl.update  = (state_q == ST_SUM);

	hbd_detect u_detect (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctrl   (ctrl),
		.sample (s_tdata[SAMPLE_W-1:0]),
		.now_ms (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
		.stat   (stat)
	);

	// first pass: mean = sum / count; second pass: rate = 60000 / mean
	assign div_start    = (state_q == ST_S1) || (state_q == ST_S2);
	assign div_dividend = (state_q == ST_S1) ? stat.sum :
		{RATE_W'(RATE_NUMERATOR), {(SUM_W-RATE_W){1'b0}}};
	assign div_divisor  = (state_q == ST_S1) ? SUM_W'(stat.count) : quotient;
	assign div_iters    = (state_q == ST_S1) ? ITER_W'(SUM_W) : ITER_W'(RATE_W);

	hbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (div_iters),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign rate_ok = (stat.count != '0) &&
		(CMP_W'(stat.count) >= CMP_W'(cfg_q.min_valid));

	always_ff @(posedge clk) begin
		if (out_load) begin
			beat_q  <= stat.beat;
			valid_q <= rate_ok;
			rate_q  <= rate_ok ? quotient[RATE_W-1:0] : '0;
		end
	end

	// hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, valid_q, rate_q, beat_q};

endmodule

// ----- bench/tb_hysteresis_beat_detector_unit.sv -----
// ----------------------------------------------------------------------------
// tb_hysteresis_beat_detector_unit: self-checking bench for the beat detector
// Streams pulse-like sample trains and noise through the block under several
// threshold, refractory and validity settings, with random source idling and
// sink stalls. A local tracker predicts each report and compares it field by
// field with what leaves the master side.
// ----------------------------------------------------------------------------
module tb_hysteresis_beat_detector_unit import hbd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT = 400000;
	localparam int TAIL_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 56;

	typedef struct packed {
		logic              beat;
		logic [RATE_W-1:0] rate;
		logic              valid;
	} beat_report_t;

	// Tracks detector state and configuration, and holds the reports still owed.
	class rate_tracker;
		logic [SAMPLE_W-1:0] upper;
		logic [SAMPLE_W-1:0] lower;
		logic [REFR_W-1:0]   refr;
		logic [MINV_W-1:0]   min_valid;
		logic                in_beat;
		logic                have_last;
		logic [TIME_W-1:0]   last_time;
		logic [TIME_W-1:0]   ring [INTERVAL_SLOTS];
		int                  ptr;
		beat_report_t        owed [$];
		int                  n_errors;

		function new();
			upper = '0;
			lower = '0;
			refr = REFR_RESET;
			min_valid = MINV_RESET;
			in_beat = 1'b0;
			have_last = 1'b0;
			last_time = '0;
			foreach (ring[i]) ring[i] = '0;
			ptr = 0;
			n_errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_UPPER: upper = val[SAMPLE_W-1:0];
				REG_LOWER: lower = val[SAMPLE_W-1:0];
				REG_REFR:  refr = val[REFR_W-1:0];
				REG_MINV:  min_valid = val[MINV_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] t);
			logic [TIME_W-1:0] elapsed;
			logic [63:0] span_sum;
			logic [63:0] mean;
			int n;
			beat_report_t r;
			elapsed = t - last_time;
			r = '0;
			if (smp > upper && !in_beat && (!have_last || elapsed > refr)) begin
				in_beat = 1'b1;
				r.beat = 1'b1;
				// the first beat only sets the time base
				if (have_last) begin
					ring[ptr] = elapsed;
					ptr = (ptr + 1) % INTERVAL_SLOTS;
				end
				last_time = t;
				have_last = 1'b1;
			end else if (smp < lower && in_beat) begin
				in_beat = 1'b0;
			end
			span_sum = '0;
			n = 0;
			foreach (ring[i]) begin
				if (ring[i] != '0) begin
					span_sum += ring[i];
					n++;
				end
			end
			if (n != 0 && n >= int'(min_valid)) begin
				mean = span_sum / 64'(n);
				r.valid = 1'b1;
				if (mean != '0)
					r.rate = RATE_W'(64'(RATE_NUMERATOR) / mean);
			end
			owed.push_back(r);
		endfunction

		function void compare(string field, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				n_errors++;
				$display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
			end
		endfunction

		function void match_report(logic [OUT_DATA_W-1:0] d);
			beat_report_t e;
			if (owed.size() == 0) begin
				n_errors++;
				$display("%0t: report expected none, got 0x%0h", $time, d);
				return;
			end
			e = owed.pop_front();
			compare("beat_start", e.beat, d[0]);
			compare("heart_rate", e.rate, d[RATE_W:1]);
			compare("rate_valid", e.valid, d[RATE_W+1]);
			compare("zero fill", 0, d[OUT_DATA_W-1:OUT_BITS]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // sample[11:0], now_ms[43:12], zero fill
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // beat_start[0], heart_rate[16:1], rate_valid[17]

	rate_tracker tracker;
	int cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	logic [TIME_W-1:0] t_ms = '0;
	int high_left = 0;
	int low_left = 0;

	hysteresis_beat_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("tb_hysteresis_beat_detector_unit: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			tracker.match_report(m_tdata);
	end

	// Called at a falling edge; returns at a falling edge with cfg_valid lowered.
	task automatic program_detector(input logic [SAMPLE_W-1:0] up, input logic [SAMPLE_W-1:0] lo,
			input logic [REFR_W-1:0] rf, input logic [MINV_W-1:0] mv);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0] idxs [4];
		vals = '{CFG_DATA_W'(up), CFG_DATA_W'(lo), CFG_DATA_W'(rf), CFG_DATA_W'(mv)};
		idxs = '{REG_UPPER, REG_LOWER, REG_REFR, REG_MINV};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.set_reg(idxs[i], vals[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] t);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W-SAMPLE_W-TIME_W){1'b0}}, t, smp};
		do @(posedge clk); while (!s_tready);
		tracker.take_sample(smp, t);
		@(negedge clk);
	endtask

	// Hold the source until every owed report has left the block.
	task automatic hold_until_reported();
		s_tvalid <= 1'b0;
		while (tracker.owed.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive_pulse_train(input int n);
		logic [SAMPLE_W-1:0] smp;
		int up;
		int lo;
		for (int k = 0; k < n; k++) begin
			up = int'(tracker.upper);
			lo = int'(tracker.lower);
			if (k == n / 2)
				hold_until_reported();
			if ($urandom_range(0, 99) < 75) begin
				// well-formed pulse: a few samples above the upper level, then below the lower
				if (high_left == 0 && low_left == 0) begin
					high_left = $urandom_range(1, 3);
					low_left = $urandom_range(2, 5);
				end
				if (high_left > 0) begin
					smp = (up == 4095) ? 12'hFFF : SAMPLE_W'($urandom_range(up + 1, 4095));
					high_left--;
				end else begin
					smp = (lo == 0) ? 12'h000 : SAMPLE_W'($urandom_range(0, lo - 1));
					low_left--;
				end
				t_ms += $urandom_range(1, int'(tracker.refr) / 3 + 40);
			end else begin
				case ($urandom_range(0, 3))
					0: smp = tracker.upper;
					1: smp = tracker.lower;
					default: smp = SAMPLE_W'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: t_ms = $urandom;
					1: ;
					default: t_ms += $urandom_range(0, 3);
				endcase
			end
			offer_sample(smp, t_ms);
		end
	endtask

	initial begin
		int prof;
		int src_pct [4];
		int sink_pct [4];
		tracker = new();
		src_pct = '{0, 60, 0, 34};
		sink_pct = '{0, 0, 60, 34};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: any nonzero sample starts the first beat
		offer_sample(12'd0, 32'd0);
		offer_sample(12'd1, 32'd5);
		hold_until_reported();
		program_detector(12'd2000, 12'd1000, 16'd300, 3'd1);
		offer_sample(12'd500, 32'd100);
		// elapsed equal to the refractory time is not enough
		offer_sample(12'd4095, 32'd305);
		offer_sample(12'd4095, 32'd306);
		offer_sample(12'd4095, 32'd700);
		// levels equal to a threshold neither end nor start a beat
		offer_sample(12'd1000, 32'd710);
		offer_sample(12'd999, 32'd720);
		offer_sample(12'd2000, 32'd800);
		offer_sample(12'd2001, 32'hFFFF_FF00);
		offer_sample(12'd0, 32'hFFFF_FF10);
		// refractory test across the time wrap
		offer_sample(12'd4095, 32'h0000_002C);
		offer_sample(12'd4095, 32'h0000_002D);
		offer_sample(12'd0, 32'h0000_0030);
		// fill the ring and wrap its pointer
		offer_sample(12'd4095, 32'h0000_01F0);
		offer_sample(12'd0, 32'h0000_0200);
		offer_sample(12'd4095, 32'h0000_0400);
		offer_sample(12'd0, 32'h0000_0410);
		offer_sample(12'd4095, 32'h0000_0600);
		offer_sample(12'd0, 32'h0000_0610);
		offer_sample(12'd4095, 32'h0000_0800);
		offer_sample(12'd4095, 32'hFFFF_FFFF);
		offer_sample(12'd0, 32'hFFFF_FFFF);
		t_ms = 32'hFFFF_FFFF;

		for (int ph = 0; ph < 8; ph++) begin
			hold_until_reported();
			case (ph)
				0: program_detector(12'd2048, 12'd1024, 16'd300, 3'd3);
				1: program_detector(12'd0, 12'd4095, 16'd0, 3'd0);
				2: program_detector(12'd4095, 12'd0, 16'd65535, 3'd7);
				3: program_detector(12'd3000, 12'd3000, 16'd65535, 3'd5);
				4: program_detector(12'd1500, 12'd500, 16'd1, 3'd6);
				5: program_detector(12'd2500, 12'd1200, 16'd250, 3'd1);
				6: program_detector(12'd3500, 12'd200, 16'd600, 3'd4);
				default: program_detector(12'd2048, 12'd1024, 16'd300, 3'd2);
			endcase
			prof = ph % 4;
			src_idle_pct = src_pct[prof];
			sink_stall_pct = sink_pct[prof];
			@(negedge clk);
			drive_pulse_train(RANDOM_PER_PHASE);
		end

		s_tvalid <= 1'b0;
		while (tracker.owed.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.n_errors == 0) begin
			$display("tb_hysteresis_beat_detector_unit: done, clean");
		end else begin
			$display("tb_hysteresis_beat_detector_unit: done, errors");
		end
		$finish;
	end

endmodule
